### rtl/pprs_pkg.sv
// Shared types, constants and sizes of the packed pixel row store.
package pprs_pkg;

   // Store geometry: row r owns word slots r*ROW_SLOTS .. r*ROW_SLOTS+ROW_SLOTS-1.
   localparam int ROWS      = 256;
   localparam int ROW_SLOTS = 256;
   localparam int WORDS     = ROWS * ROW_SLOTS;
   localparam int ADDR_W    = $clog2(WORDS);
   localparam int SLOT_W    = $clog2(ROW_SLOTS);

   // Field and arithmetic widths.
   localparam int BPP_W      = 6;
   localparam int COL_W      = 13;
   localparam int BIT_W      = 18;          // column * bits per pixel
   localparam int BLK_W      = BIT_W - 5;   // word offset of a pixel in its row
   localparam int LAST_W     = BLK_W + 1;
   localparam int CSR_ADDR_W = 5;

   // Command codes.
   typedef enum logic [1:0] {
      CMD_LOAD_WORD   = 2'd0,
      CMD_READ_PIXEL  = 2'd1,
      CMD_WRITE_PIXEL = 2'd2,
      CMD_READ_WORD   = 2'd3
   } cmd_type;

   // Configuration register indexes; register i lies at byte address 4*i.
   typedef enum logic [2:0] {
      REG_BPP   = 3'd0,
      REG_RED   = 3'd1,
      REG_GREEN = 3'd2,
      REG_BLUE  = 3'd3,
      REG_ALPHA = 3'd4
   } reg_index_type;

   // One input item.
   typedef struct packed {
      cmd_type     command;
      logic [7:0]  row;
      logic [12:0] column;
      logic [7:0]  word_index;
      logic [31:0] word_in;
      logic [31:0] red_in;
      logic [31:0] green_in;
      logic [31:0] blue_in;
      logic [31:0] alpha_in;
      logic [3:0]  channel_enable;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [31:0] red_out;
      logic [31:0] green_out;
      logic [31:0] blue_out;
      logic [31:0] alpha_out;
      logic [31:0] raw_pixel;
      logic [31:0] word_out;
      logic        range_error;
   } rsp_item_type;

   // Decoded configuration seen by the datapath. Channels are red, green, blue, alpha.
   typedef struct packed {
      logic [BPP_W-1:0]  bpp;        // effective pixel size, 1..32
      logic [31:0]       pix_mask;   // low bpp bits set
      logic [3:0][31:0]  mask;
      logic [3:0][4:0]   low_pos;    // lowest set bit of each mask
   } cfg_type;

   // Results of the pixel datapath.
   typedef struct packed {
      logic [3:0][31:0] chan_out;
      logic [31:0]      raw;
      logic [63:0]      pair_new;    // both words after a channel write
   } pxu_out_type;

endpackage

### rtl/packed_pixel_row_store.sv
// Top level of the packed pixel row store: command sequencer around the word memory.
//
// Usage. An item is a command (load word, read pixel, write pixel channels, read word)
// presented on req_item and taken at a rising edge with start high and busy low.
// Every item yields exactly one result on rsp_item, valid for the single cycle in
// which rsp_strobe is high; the receiver cannot hold it off and must take it then.
// Configuration (pixel size and four channel masks) is written through the APB-style
// port while the block is idle; pready is always high.
// Items are handled one at a time, and the next item may be accepted in the cycle the
// result is shown. Each item passes through S_CALC, which forms the pixel's bit position,
// and S_ISSUE, which checks the range and writes a loaded word or reads the first word;
// read word then shows the word, while a pixel access reads a straddled second word,
// forms the result in S_EXEC and, for a write, writes back each word in turn, since the
// sequencer reads or writes only one memory word at a time.
// Reset clears the sequencer and loads the register reset values; memory contents are
// undefined until written. No clearing pass is run.
module packed_pixel_row_store
   import pprs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   output logic                  rsp_strobe,
   output rsp_item_type          rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_ISSUE,
      S_WAIT0,
      S_WAIT1,
      S_EXEC,
      S_WRITE1
   } state_type;

   state_type        state_ff, state_in;
   req_item_type     item_ff, item_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic [ADDR_W-1:0] addr0_ff, addr0_in;
   logic [ADDR_W-1:0] addr1_ff, addr1_in;
   logic [4:0]       start_ff, start_in;
   logic             two_ff, two_in;
   logic [31:0]      w0_ff, w0_in;
   logic [31:0]      w1_ff, w1_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   cfg_type          cfg;
   pxu_out_type      pxu;
   logic [3:0][31:0] chan_in;

   logic             mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [31:0]      mem_wr_data;
   logic             mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [31:0]      mem_rd_data;

   // Address decode signals formed in the issue cycle.
   logic [BLK_W-1:0]  blk;
   logic [4:0]        bit_start;
   logic              two_words;
   logic [LAST_W-1:0] last_slot;
   logic              is_word_cmd;
   logic              range_bad;
   logic [SLOT_W-1:0] slot;
   logic [ADDR_W-1:0] addr_now;

   pprs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pprs_ram #(
      .WIDTH (32),
      .DEPTH (WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign chan_in = {item_ff.alpha_in, item_ff.blue_in, item_ff.green_in, item_ff.red_in};

   pprs_pixel u_pixel (
      .cfg       (cfg),
      .pair      ({w1_ff, w0_ff}),
      .bit_start (start_ff),
      .chan_in   (chan_in),
      .chan_en   (item_ff.channel_enable),
      .result    (pxu)
   );

   // Word position, straddle and range checks of the latched item.
   always_comb begin
      blk         = bit_ff[BIT_W-1:5];
      bit_start   = bit_ff[4:0];
      two_words   = (7'(bit_start) + 7'(cfg.bpp)) > 7'd32;
      last_slot   = LAST_W'(blk) + LAST_W'(two_words);
      is_word_cmd = (item_ff.command == CMD_LOAD_WORD) || (item_ff.command == CMD_READ_WORD);
      if (32'(item_ff.row) >= 32'(ROWS)) begin
         range_bad = 1'b1;
      end else if (is_word_cmd) begin
         range_bad = 32'(item_ff.word_index) >= 32'(ROW_SLOTS);
      end else begin
         range_bad = 32'(last_slot) >= 32'(ROW_SLOTS);
      end
      slot     = is_word_cmd ? SLOT_W'(item_ff.word_index) : blk[SLOT_W-1:0];
      addr_now = ADDR_W'(item_ff.row) * ADDR_W'(ROW_SLOTS) + ADDR_W'(slot);
   end

   // Sequencer next state, memory controls and result formation.
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      bit_in        = bit_ff;
      addr0_in      = addr0_ff;
      addr1_in      = addr1_ff;
      start_in      = start_ff;
      two_in        = two_ff;
      w0_in         = w0_ff;
      w1_in         = w1_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr0_ff;
      mem_wr_data   = pxu.pair_new[31:0];
      mem_rd_en     = 1'b0;
      mem_rd_addr   = addr_now;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in  = req_item;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            bit_in   = BIT_W'(item_ff.column) * BIT_W'(cfg.bpp);
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            addr0_in = addr_now;
            addr1_in = addr_now + ADDR_W'(1);
            start_in = bit_start;
            two_in   = two_words;
            if (range_bad) begin
               rsp_strobe_in           = 1'b1;
               rsp_item_in.range_error = 1'b1;
               state_in                = S_IDLE;
            end else if (item_ff.command == CMD_LOAD_WORD) begin
               mem_wr_en     = 1'b1;
               mem_wr_addr   = addr_now;
               mem_wr_data   = item_ff.word_in;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_WAIT0;
            end
         end
         S_WAIT0: begin
            if (item_ff.command == CMD_READ_WORD) begin
               rsp_strobe_in        = 1'b1;
               rsp_item_in.word_out = mem_rd_data;
               state_in             = S_IDLE;
            end else begin
               w0_in = mem_rd_data;
               if (two_ff) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = addr1_ff;
                  state_in    = S_WAIT1;
               end else begin
                  w1_in    = 32'd0;
                  state_in = S_EXEC;
               end
            end
         end
         S_WAIT1: begin
            w1_in    = mem_rd_data;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (item_ff.command == CMD_READ_PIXEL) begin
               rsp_strobe_in         = 1'b1;
               rsp_item_in.red_out   = pxu.chan_out[0];
               rsp_item_in.green_out = pxu.chan_out[1];
               rsp_item_in.blue_out  = pxu.chan_out[2];
               rsp_item_in.alpha_out = pxu.chan_out[3];
               rsp_item_in.raw_pixel = pxu.raw;
               state_in              = S_IDLE;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = addr0_ff;
               mem_wr_data = pxu.pair_new[31:0];
               if (two_ff) begin
                  state_in = S_WRITE1;
               end else begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         S_WRITE1: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = addr1_ff;
            mem_wr_data   = pxu.pair_new[63:32];
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and registered outputs; only control state is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         item_ff       <= item_in;
         bit_ff        <= bit_in;
         addr0_ff      <= addr0_in;
         addr1_ff      <= addr1_in;
         start_ff      <= start_in;
         two_ff        <= two_in;
         w0_ff         <= w0_in;
         w1_ff         <= w1_in;
         rsp_item_ff   <= rsp_item_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

### rtl/pprs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module pprs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/pprs_csr.sv
// Configuration registers behind the APB-style port and their decoded form.
module pprs_csr
   import pprs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [BPP_W-1:0] bpp_ff;
   logic [3:0][31:0] mask_ff;
   logic             wr_stb;
   logic [2:0]       reg_idx;
   logic [BPP_W-1:0] eff_bpp;

   // Position of the lowest set bit; zero for an empty mask.
   function automatic logic [4:0] low_bit_pos(input logic [31:0] m);
      logic [31:0] one_hot;
      logic [4:0]  pos;
      one_hot = m & (~m + 32'd1);
      pos = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (one_hot[i]) begin
            pos = pos | 5'(i);
         end
      end
      return pos;
   endfunction

   assign pready  = 1'b1;
   assign wr_stb  = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff     <= BPP_W'(24);
         mask_ff[0] <= 32'h00FF_0000;
         mask_ff[1] <= 32'h0000_FF00;
         mask_ff[2] <= 32'h0000_00FF;
         mask_ff[3] <= 32'h0000_0000;
      end else if (wr_stb) begin
         unique case (reg_idx)
            REG_BPP:   bpp_ff     <= pwdata[BPP_W-1:0];
            REG_RED:   mask_ff[0] <= pwdata;
            REG_GREEN: mask_ff[1] <= pwdata;
            REG_BLUE:  mask_ff[2] <= pwdata;
            REG_ALPHA: mask_ff[3] <= pwdata;
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (reg_idx)
         REG_BPP:   prdata = {{(32-BPP_W){1'b0}}, bpp_ff};
         REG_RED:   prdata = mask_ff[0];
         REG_GREEN: prdata = mask_ff[1];
         REG_BLUE:  prdata = mask_ff[2];
         REG_ALPHA: prdata = mask_ff[3];
         default:   prdata = 32'd0;
      endcase
   end

   // A pixel size of zero acts as one and anything above 32 as 32.
   always_comb begin
      if (bpp_ff == '0) begin
         eff_bpp = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(32)) begin
         eff_bpp = BPP_W'(32);
      end else begin
         eff_bpp = bpp_ff;
      end
   end

   // Decoded view for the datapath.
   always_comb begin
      cfg.bpp      = eff_bpp;
      cfg.pix_mask = 32'hFFFF_FFFF >> (BPP_W'(32) - eff_bpp);
      cfg.mask     = mask_ff;
      for (int k = 0; k < 4; k++) begin
         cfg.low_pos[k] = low_bit_pos(mask_ff[k]);
      end
   end

endmodule

### rtl/pprs_pixel.sv
// Pixel datapath: extracts a pixel and its channels from two words and merges a write back.
module pprs_pixel
   import pprs_pkg::*;
(
   input  cfg_type          cfg,
   input  logic [63:0]      pair,       // word 1 above word 0
   input  logic [4:0]       bit_start,  // first pixel bit within word 0
   input  logic [3:0][31:0] chan_in,
   input  logic [3:0]       chan_en,
   output pxu_out_type      result
);

   always_comb begin
      logic [63:0] shifted;
      logic [31:0] pix;
      logic [31:0] merged;
      logic [63:0] place_mask;
      logic [63:0] placed;

      // The pixel starts at bit_start and may run into word 1.
      shifted = pair >> bit_start;
      pix     = shifted[31:0] & cfg.pix_mask;

      // Channel extraction, each shifted down to bit zero.
      for (int k = 0; k < 4; k++) begin
         result.chan_out[k] = (pix & cfg.mask[k]) >> cfg.low_pos[k];
      end
      result.raw = pix;

      // Enabled channels are applied in red, green, blue, alpha order.
      merged = pix;
      for (int k = 0; k < 4; k++) begin
         if (chan_en[k]) begin
            merged = (merged & ~cfg.mask[k]) |
                     ((chan_in[k] << cfg.low_pos[k]) & cfg.mask[k]);
         end
      end
      merged = merged & cfg.pix_mask;

      // Only the pixel's own bits of both words change.
      place_mask      = {32'd0, cfg.pix_mask} << bit_start;
      placed          = {32'd0, merged} << bit_start;
      result.pair_new = (pair & ~place_mask) | (placed & place_mask);
   end

endmodule
